// ===== sv/byte_stream_fingerprint_defines.svh =====
// assertion macros for the byte stream fingerprint block
`ifndef BYTE_STREAM_FINGERPRINT_DEFINES_SVH
`define BYTE_STREAM_FINGERPRINT_DEFINES_SVH
`ifndef SYNTHESIS
`define BSF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BSF_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define BSF_ASSERT(name, prop, msg)
`define BSF_ASSERT_NEXT(name, pre, post, msg)
`endif
`endif

// ===== sv/bsf_pkg.sv =====
// types, constants and hash step for the byte stream fingerprint block
`default_nettype none
package bsf_pkg;

  localparam int unsigned CAPACITY_DEF = 65536;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

  localparam int unsigned HIST_LEN = 27;
  localparam int unsigned AFF_LEN  = 28;
  localparam int unsigned FRAC_LEN = 17;

  localparam logic [AFF_LEN-1:0][7:0]  AFF_PAT  = {"swingPair_", "affine_coordinates"};
  localparam logic [FRAC_LEN-1:0][7:0] FRAC_PAT = {"crossRatio_", "mobius"};

  typedef enum logic [1:0] {
    ST_ACCEPTED      = 2'd0,
    ST_CAP_REFUSED   = 2'd1,
    ST_EMPTY_REFUSED = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [16:0] byte_count;
    logic [63:0] content_hash;
    logic        affine_found;
    logic        fractional_found;
  } out_word_t;

  // multiply by the 64-bit prime 2^40 + 0x1b3 as shifts and adds
  function automatic logic [63:0] fnv_mult(input logic [63:0] h);
    fnv_mult = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
  endfunction

endpackage
`default_nettype wire

// ===== sv/bsf_in_stage.sv =====
// input register of the byte stream fingerprint block
`default_nettype none
module bsf_in_stage
  import bsf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_word_t in_data_i,
  input  wire logic     take_i,
  output logic          item_valid_o,
  output in_word_t      item_o
);

  logic     valid_q, valid_d;
  in_word_t word_q;
  logic     load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = word_q;

endmodule
`default_nettype wire

// ===== sv/bsf_fold.sv =====
// hash, count and pattern state with result forming
`default_nettype none
`include "byte_stream_fingerprint_defines.svh"
module bsf_fold
  import bsf_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     item_valid_i,
  input  wire in_word_t item_i,
  input  wire logic     space_i,
  output logic          take_o,
  output logic          res_valid_o,
  output out_word_t     res_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);

  logic [63:0]                hash_q, hash_d, hash_n;
  logic [CNT_W-1:0]           cnt_q, cnt_d, cnt_n;
  logic [HIST_LEN-1:0][7:0]   hist_q, hist_d;
  logic                       aff_q, aff_d, aff_n;
  logic                       frac_q, frac_d, frac_n;
  logic [HIST_LEN:0][7:0]     window;
  logic                       accept_byte;

  assign take_o      = item_valid_i && (!item_i.is_last || space_i);
  assign res_valid_o = take_o && item_i.is_last;

  assign accept_byte = item_i.has_byte && (cnt_q != CapCnt);
  // newest byte at index 0
  assign window      = {hist_q, item_i.data_byte};

  always_comb begin
    hash_n = hash_q;
    cnt_n  = cnt_q;
    aff_n  = aff_q;
    frac_n = frac_q;
    if (accept_byte) begin
      hash_n = fnv_mult(hash_q ^ {56'd0, item_i.data_byte});
      cnt_n  = cnt_q + CNT_W'(1);
      aff_n  = aff_q || (window == AFF_PAT);
      frac_n = frac_q || (window[FRAC_LEN-1:0] == FRAC_PAT);
    end
  end

  always_comb begin
    res_o = '0;
    priority if (cnt_n == CapCnt) begin
      res_o.status     = ST_CAP_REFUSED;
      res_o.byte_count = 17'(cnt_n);
    end else if (cnt_n == '0) begin
      res_o.status = ST_EMPTY_REFUSED;
    end else begin
      res_o.status           = ST_ACCEPTED;
      res_o.byte_count       = 17'(cnt_n);
      res_o.content_hash     = hash_n;
      res_o.affine_found     = aff_n;
      res_o.fractional_found = frac_n;
    end
  end

  always_comb begin
    hash_d = hash_q;
    cnt_d  = cnt_q;
    hist_d = hist_q;
    aff_d  = aff_q;
    frac_d = frac_q;
    if (take_o) begin
      if (item_i.is_last) begin
        hash_d = FNV_BASIS;
        cnt_d  = '0;
        hist_d = '0;
        aff_d  = 1'b0;
        frac_d = 1'b0;
      end else begin
        hash_d = hash_n;
        cnt_d  = cnt_n;
        aff_d  = aff_n;
        frac_d = frac_n;
        if (accept_byte) begin
          hist_d = window[HIST_LEN-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= FNV_BASIS;
      cnt_q  <= '0;
      hist_q <= '0;
      aff_q  <= 1'b0;
      frac_q <= 1'b0;
    end else begin
      hash_q <= hash_d;
      cnt_q  <= cnt_d;
      hist_q <= hist_d;
      aff_q  <= aff_d;
      frac_q <= frac_d;
    end
  end

  `BSF_ASSERT(a_cnt_bounded, cnt_q <= CapCnt, "byte count above capacity")
  `BSF_ASSERT_NEXT(a_last_clears, res_valid_o, (cnt_q == '0) && (hash_q == FNV_BASIS) && !aff_q && !frac_q, "state not cleared after last word")
  `BSF_ASSERT_NEXT(a_full_holds, (cnt_q == CapCnt) && take_o && !item_i.is_last, $stable(hash_q) && $stable(hist_q), "hash moved after capacity reached")

endmodule
`default_nettype wire

// ===== sv/bsf_out_stage.sv =====
// result register of the byte stream fingerprint block
`default_nettype none
`include "byte_stream_fingerprint_defines.svh"
module bsf_out_stage
  import bsf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire out_word_t res_i,
  output logic           space_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_data_o
);

  logic      valid_q, valid_d;
  out_word_t word_q;

  assign space_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = word_q;

  `BSF_ASSERT(a_no_overwrite, !(load_i && valid_q && out_stall_i), "result overwritten while stalled")
  `BSF_ASSERT(a_empty_zero, !(valid_q && (word_q.status == ST_EMPTY_REFUSED)) || ((word_q.byte_count == '0) && (word_q.content_hash == '0)), "empty result carries data")

endmodule
`default_nettype wire

// ===== sv/byte_stream_fingerprint.sv =====
// top level: FNV-1a 64-bit fingerprint of a byte stream with pattern flags
//
//   channel  direction  handshake              word
//   in       input      in_valid_i/in_stall_o  in_word_t  (data_byte, has_byte, is_last)
//   out      output     out_valid_o/out_stall_i out_word_t (status, count, hash, flags)
//
// one byte word per cycle sustained; the hash step is one multiply by the prime as
// shifts and adds between the input register and the state registers
// a result is written to the output register when its last word is taken from the input register
// reset clears both valid bits, hash to the offset basis, count, history and flags
// an output stall holds up only a last word that finds the output register full
`default_nettype none
module byte_stream_fingerprint
  import bsf_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_word_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_word_t     out_data_o
);

  logic      item_valid;
  in_word_t  item;
  logic      take;
  logic      space;
  logic      res_valid;
  out_word_t res;

  bsf_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  bsf_fold #(
    .CAPACITY (CAPACITY)
  ) u_fold (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .space_i      (space),
    .take_o       (take),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  bsf_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
